/* rtl/core/glos_pkg.sv */
// Shared constants and command/status types of the grid line-of-sight checker.
package glos_pkg;

   // Map geometry
   localparam int GRID_SIDE = 128;
   localparam int CELL_W    = $clog2(GRID_SIDE);
   localparam int MAP_DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int MAP_AW    = 2 * CELL_W;

   // Field and arithmetic widths
   localparam int COORD_W = 8;
   localparam int DIM_W   = 8;
   localparam int AXIS_W  = CELL_W;
   localparam int PROD_W  = 2 * AXIS_W;
   localparam int ERR_W   = PROD_W + 3;

   // Item operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // CSR register indexes (paddr[2])
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_step;
      logic write;
      logic load;
      logic prep;
      logic mul_prod;
      logic mul_sq;
      logic init;
      logic step_walk;
      logic step_diag;
   } glos_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic out_range;
      logic adjacent;
      logic straight;
      logic knight;
      logic blocked;
      logic err_gt;
      logic major_last;
   } glos_status_type;

endpackage

/* rtl/core/glos_ctrl.sv */
// Sequencer: map clearing pass, item intake and line walk control.
module glos_ctrl import glos_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_operation,
   input  glos_status_type st,
   output glos_cmd_type    cmd,
   input  logic            out_ready,
   output logic            fin_valid,
   output logic            fin_visible
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_PREP  = 4'd2;
   localparam logic [3:0] S_CLASS = 4'd3;
   localparam logic [3:0] S_MULP  = 4'd4;
   localparam logic [3:0] S_MULS  = 4'd5;
   localparam logic [3:0] S_INIT  = 4'd6;
   localparam logic [3:0] S_WALK  = 4'd7;
   localparam logic [3:0] S_DIAG  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       res_ff, res_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      cmd       = '0;
      req_stall = 1'b1;
      fin_valid = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (st.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_operation == OP_QUERY) begin
                  cmd.load = 1'b1;
                  state_in = S_PREP;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_CLASS;
         end
         S_CLASS: begin
            if (st.out_range) begin
               res_in   = 1'b0;
               state_in = S_DONE;
            end else if (st.adjacent) begin
               res_in   = 1'b1;
               state_in = S_DONE;
            end else if (st.straight) begin
               state_in = S_INIT;
            end else begin
               state_in = S_MULP;
            end
         end
         S_MULP: begin
            cmd.mul_prod = 1'b1;
            state_in     = S_MULS;
         end
         S_MULS: begin
            cmd.mul_sq = 1'b1;
            state_in   = S_INIT;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (st.blocked) begin
               res_in   = 1'b0;
               state_in = S_DONE;
            end else if (st.knight) begin
               // knight offset: near orthogonal cell is clear
               res_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.step_walk = 1'b1;
               if (st.err_gt) begin
                  state_in = S_DIAG;
               end else if (st.major_last) begin
                  res_in   = 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_DIAG: begin
            if (st.blocked) begin
               res_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               cmd.step_diag = 1'b1;
               if (st.major_last) begin
                  res_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_DONE: begin
            fin_valid = 1'b1;
            if (out_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign fin_visible = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         res_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

endmodule

/* rtl/core/glos_dp.sv */
// Datapath: opacity map memory, endpoint classification, error terms and walk position.
module glos_dp import glos_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  glos_cmd_type        cmd,
   output glos_status_type     st,
   input  logic [CELL_W-1:0]   req_cell_x,
   input  logic [CELL_W-1:0]   req_cell_y,
   input  logic                req_opaque,
   input  logic [COORD_W-1:0]  req_from_x,
   input  logic [COORD_W-1:0]  req_from_y,
   input  logic [COORD_W-1:0]  req_to_x,
   input  logic [COORD_W-1:0]  req_to_y,
   input  logic [DIM_W-1:0]    width_eff,
   input  logic [DIM_W-1:0]    height_eff
);

   // Opacity map and its read register
   logic                  map_ff [MAP_DEPTH];
   logic                  rd_bit_ff;
   logic [MAP_AW-1:0]     clr_cnt_ff, clr_cnt_in;

   // Query registers
   logic [COORD_W-1:0]    fx_ff, fy_ff, tx_ff, ty_ff;
   logic [AXIS_W-1:0]     ax_ff, ay_ff, ax_in, ay_in;
   logic                  neg_x_ff, neg_y_ff, major_x_ff;
   logic                  straight_ff, knight_ff, adjacent_ff, out_range_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [PROD_W:0]       inc_ff;
   logic [COORD_W-1:0]    cx_ff, cy_ff, cx_in, cy_in;

   // Combinational terms
   logic [COORD_W:0]      dx, dy, adx, ady;
   logic [COORD_W-1:0]    axf, ayf;
   logic [AXIS_W-1:0]     mul_a, mul_b, minor_ax;
   logic [PROD_W-1:0]     mul_p;
   logic signed [ERR_W-1:0] prod_s, twice_s, inc_s, sum;
   logic [COORD_W-1:0]    cx_step, cy_step;
   logic                  ge, gt;
   logic                  mem_we, mem_wd;
   logic [MAP_AW-1:0]     mem_wa;

   // Endpoint differences and their magnitudes
   always_comb begin
      dx  = {1'b0, tx_ff} - {1'b0, fx_ff};
      dy  = {1'b0, ty_ff} - {1'b0, fy_ff};
      adx = dx[COORD_W] ? -dx : dx;
      ady = dy[COORD_W] ? -dy : dy;
      axf = adx[COORD_W-1:0];
      ayf = ady[COORD_W-1:0];
      ax_in = axf[AXIS_W-1:0];
      ay_in = ayf[AXIS_W-1:0];
   end

   // Shared multiplier: ax*ay, then the minor magnitude squared
   assign minor_ax = major_x_ff ? ay_ff : ax_ff;
   assign mul_a    = cmd.mul_sq ? minor_ax : ax_ff;
   assign mul_b    = cmd.mul_sq ? minor_ax : ay_ff;
   assign mul_p    = mul_a * mul_b;

   // Error update terms
   assign prod_s  = signed'(ERR_W'(prod_ff));
   assign twice_s = signed'(ERR_W'({prod_ff, 1'b0}));
   assign inc_s   = signed'(ERR_W'(inc_ff));
   assign sum     = err_ff + inc_s;
   assign ge      = (sum >= prod_s);
   assign gt      = (sum > prod_s);

   // One step along each axis toward the target
   assign cx_step = neg_x_ff ? cx_ff - COORD_W'(1) : cx_ff + COORD_W'(1);
   assign cy_step = neg_y_ff ? cy_ff - COORD_W'(1) : cy_ff + COORD_W'(1);

   // Walk position and error register next values
   always_comb begin
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      err_in = err_ff;
      if (cmd.mul_sq) begin
         err_in = signed'(ERR_W'(mul_p));
      end
      if (cmd.init) begin
         cx_in = fx_ff;
         cy_in = fy_ff;
         if (major_x_ff) begin
            cx_in = neg_x_ff ? fx_ff - COORD_W'(1) : fx_ff + COORD_W'(1);
         end else begin
            cy_in = neg_y_ff ? fy_ff - COORD_W'(1) : fy_ff + COORD_W'(1);
         end
         // equal magnitudes: the first cell already turns the corner
         if (!straight_ff && err_ff == prod_s) begin
            err_in = err_ff - twice_s;
            if (major_x_ff) begin
               cy_in = neg_y_ff ? fy_ff - COORD_W'(1) : fy_ff + COORD_W'(1);
            end else begin
               cx_in = neg_x_ff ? fx_ff - COORD_W'(1) : fx_ff + COORD_W'(1);
            end
         end
      end
      if (cmd.step_walk) begin
         if (!straight_ff) begin
            err_in = ge ? sum - twice_s : sum;
            if (ge) begin
               if (major_x_ff) cy_in = cy_step;
               else            cx_in = cx_step;
            end
         end
         if (straight_ff || !gt) begin
            if (major_x_ff) cx_in = cx_step;
            else            cy_in = cy_step;
         end
      end
      if (cmd.step_diag) begin
         if (major_x_ff) cx_in = cx_step;
         else            cy_in = cy_step;
      end
   end

   // Status toward the controller
   always_comb begin
      st.clear_last = (clr_cnt_ff == MAP_AW'(MAP_DEPTH - 1));
      st.out_range  = out_range_ff;
      st.adjacent   = adjacent_ff;
      st.straight   = straight_ff;
      st.knight     = knight_ff;
      st.blocked    = rd_bit_ff && (cx_ff < COORD_W'(GRID_SIDE))
                      && (cy_ff < COORD_W'(GRID_SIDE));
      st.err_gt     = !straight_ff && gt;
      st.major_last = major_x_ff ? (cx_step == tx_ff) : (cy_step == ty_ff);
   end

   // Clearing pass counter
   assign clr_cnt_in = cmd.clear_step ? clr_cnt_ff + MAP_AW'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) clr_cnt_ff <= '0;
      else       clr_cnt_ff <= clr_cnt_in;
   end

   // Map write port: clearing pass or write beat
   assign mem_we = cmd.clear_step || cmd.write;
   assign mem_wa = cmd.clear_step ? clr_cnt_ff : {req_cell_y, req_cell_x};
   assign mem_wd = cmd.clear_step ? 1'b0 : req_opaque;

   // Map memory; the read follows the next walk position so the data
   // lines up with the position registers
   always_ff @(posedge clock) begin
      if (mem_we) map_ff[mem_wa] <= mem_wd;
      rd_bit_ff <= map_ff[{cy_in[CELL_W-1:0], cx_in[CELL_W-1:0]}];
   end

   // Query payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         fx_ff <= req_from_x;
         fy_ff <= req_from_y;
         tx_ff <= req_to_x;
         ty_ff <= req_to_y;
      end
      if (cmd.prep) begin
         ax_ff        <= ax_in;
         ay_ff        <= ay_in;
         neg_x_ff     <= dx[COORD_W];
         neg_y_ff     <= dy[COORD_W];
         major_x_ff   <= (axf >= ayf);
         straight_ff  <= (axf == '0) || (ayf == '0);
         adjacent_ff  <= (axf < COORD_W'(2)) && (ayf < COORD_W'(2));
         knight_ff    <= ((axf == COORD_W'(1)) && (ayf == COORD_W'(2)))
                         || ((axf == COORD_W'(2)) && (ayf == COORD_W'(1)));
         out_range_ff <= (fx_ff >= width_eff) || (tx_ff >= width_eff)
                         || (fy_ff >= height_eff) || (ty_ff >= height_eff);
      end
      if (cmd.mul_prod) prod_ff <= mul_p;
      if (cmd.mul_sq)   inc_ff  <= {mul_p, 1'b0};
      err_ff <= err_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
   end

endmodule

/* rtl/core/grid_line_of_sight_check.sv */
// Top level of the grid line-of-sight checker: CSR block, result register and core.
//
// Usage:
// - req_ channel carries one item per beat. operation 0 writes one cell of the
//   128x128 opacity map (no result beat); operation 1 asks whether to_x/to_y
//   is in sight of from_x/from_y and gives one rsp_ beat carrying visible.
// - csr_ is an APB-style port: grid_width at byte address 0, grid_height at 4.
//   Values above 128 act as 128; write them only while no query is in flight.
// - A write beat leaves the core idle and ready for the next item. A query
//   decided from its endpoints alone passes the prep and classify states
//   before its result goes to the output register; a straight row or column
//   adds init and the walk, and any other line also the multiply steps
//   before init. The walk reads one map cell per cycle, visiting each cell
//   along the major axis and each diagonal corner cell.
// - Items are taken one at a time: req_stall is low only while the core is
//   idle. A finished result sits in an output register, so the next item is
//   taken while rsp_valid waits under rsp_stall; the core holds its next
//   result until that register is free.
// - After reset the map is swept clear, one cell per cycle, with req_stall
//   held high; CSR writes are taken during the sweep.
module grid_line_of_sight_check import glos_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // item channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_operation,
   input  logic [CELL_W-1:0]   req_cell_x,
   input  logic [CELL_W-1:0]   req_cell_y,
   input  logic                req_opaque,
   input  logic [COORD_W-1:0]  req_from_x,
   input  logic [COORD_W-1:0]  req_from_y,
   input  logic [COORD_W-1:0]  req_to_x,
   input  logic [COORD_W-1:0]  req_to_y,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_visible,
   // CSR port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   logic [DIM_W-1:0] grid_width_ff, grid_width_in;
   logic [DIM_W-1:0] grid_height_ff, grid_height_in;
   logic [DIM_W-1:0] width_eff, height_eff;
   logic             csr_wr;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_visible_ff, rsp_visible_in;
   logic             out_ready, fin_valid, fin_visible;
   glos_cmd_type     cmd;
   glos_status_type  st;

   // CSR write and read
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_GRID_WIDTH) grid_width_in  = csr_pwdata[DIM_W-1:0];
         else                                grid_height_in = csr_pwdata[DIM_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_GRID_HEIGHT) ? 32'(grid_height_ff)
                                                         : 32'(grid_width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= DIM_W'(GRID_SIDE);
         grid_height_ff <= DIM_W'(GRID_SIDE);
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   // Oversized dimensions act as the full map side
   assign width_eff  = (grid_width_ff > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE)
                                                           : grid_width_ff;
   assign height_eff = (grid_height_ff > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE)
                                                            : grid_height_ff;

   // Result register
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_visible_in = rsp_visible_ff;
      if (fin_valid && out_ready) begin
         rsp_valid_in   = 1'b1;
         rsp_visible_in = fin_visible;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      rsp_visible_ff <= rsp_visible_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

   glos_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .st            (st),
      .cmd           (cmd),
      .out_ready     (out_ready),
      .fin_valid     (fin_valid),
      .fin_visible   (fin_visible)
   );

   glos_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_cell_x (req_cell_x),
      .req_cell_y (req_cell_y),
      .req_opaque (req_opaque),
      .req_from_x (req_from_x),
      .req_from_y (req_from_y),
      .req_to_x   (req_to_x),
      .req_to_y   (req_to_y),
      .width_eff  (width_eff),
      .height_eff (height_eff)
   );

endmodule

/* test/sight_query_checker.sv */
// Watches item, result and CSR traffic of the line-of-sight block and checks each visible bit.
module sight_query_checker import glos_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_operation,
   input  logic [CELL_W-1:0]  req_cell_x,
   input  logic [CELL_W-1:0]  req_cell_y,
   input  logic               req_opaque,
   input  logic [COORD_W-1:0] req_from_x,
   input  logic [COORD_W-1:0] req_from_y,
   input  logic [COORD_W-1:0] req_to_x,
   input  logic [COORD_W-1:0] req_to_y,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_visible,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 mismatch_count,
   output int                 pending_count,
   output int                 write_count,
   output int                 query_count,
   output int                 clear_count
);

   // Shadow copy of the opacity map and the grid size registers
   logic             opacity_map [MAP_DEPTH];
   logic [DIM_W-1:0] grid_width_q;
   logic [DIM_W-1:0] grid_height_q;

   // Visible bits predicted for queries whose result beat has not come yet
   bit               visible_due [$];

   // Opacity of a cell; anything off the map reads as clear
   function automatic bit cell_opaque(int x, int y);
      if (x < 0 || y < 0 || x >= GRID_SIDE || y >= GRID_SIDE)
         return 1'b0;
      return opacity_map[MAP_AW'(y * GRID_SIDE + x)] === 1'b1;
   endfunction

   // Line-of-sight decision for one query against the current map and grid size
   function automatic bit sight_line_clear(int fx, int fy, int tx, int ty);
      int w, h, dx, dy, ax, ay, sx, sy, prod, twice, err, inc, cx, cy;
      int maj, mnr;
      int cur [2];
      int fin [2];
      int stp [2];
      int len [2];
      w = (grid_width_q > GRID_SIDE) ? GRID_SIDE : int'(grid_width_q);
      h = (grid_height_q > GRID_SIDE) ? GRID_SIDE : int'(grid_height_q);
      if (fx >= w || fy >= h || tx >= w || ty >= h)
         return 1'b0;
      dx = tx - fx;
      dy = ty - fy;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      // same or neighboring cells
      if (ax < 2 && ay < 2)
         return 1'b1;

      // straight row or column: only the cells strictly between
      if (dx == 0 || dy == 0) begin
         sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
         sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
         cx = fx + sx;
         cy = fy + sy;
         while (cx != tx || cy != ty) begin
            if (cell_opaque(cx, cy))
               return 1'b0;
            cx += sx;
            cy += sy;
         end
         return 1'b1;
      end

      sx = (dx < 0) ? -1 : 1;
      sy = (dy < 0) ? -1 : 1;
      // knight offset: clear orthogonal neighbor of the viewer decides at once
      if (ax == 1) begin
         if (ay == 2 && !cell_opaque(fx, fy + sy))
            return 1'b1;
      end else if (ay == 1) begin
         if (ax == 2 && !cell_opaque(fx + sx, fy))
            return 1'b1;
      end

      // general walk along the major axis with squared error terms
      maj    = (ax >= ay) ? 0 : 1;
      mnr    = 1 - maj;
      len[0] = ax;
      len[1] = ay;
      stp[0] = sx;
      stp[1] = sy;
      fin[0] = tx;
      fin[1] = ty;
      cur[0] = fx;
      cur[1] = fy;
      prod   = ax * ay;
      twice  = prod * 2;
      err    = len[mnr] * len[mnr];
      inc    = err * 2;
      cur[maj] += stp[maj];
      if (err == prod) begin
         cur[mnr] += stp[mnr];
         err -= twice;
      end
      while (cur[maj] != fin[maj]) begin
         if (cell_opaque(cur[0], cur[1]))
            return 1'b0;
         err += inc;
         if (err > prod) begin
            // diagonal step: the corner cell counts too
            cur[mnr] += stp[mnr];
            if (cell_opaque(cur[0], cur[1]))
               return 1'b0;
            err -= twice;
         end else if (err == prod) begin
            cur[mnr] += stp[mnr];
            err -= twice;
         end
         cur[maj] += stp[maj];
      end
      return 1'b1;
   endfunction

   task automatic flag_mismatch(string what, int want, logic got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at %0t: %s, expected %0d, got %b", $realtime, what, want, got);
   endtask

   // Track every beat and CSR write at the clock edge that takes it
   always @(posedge clock) begin
      if (reset) begin
         foreach (opacity_map[i])
            opacity_map[i] = 1'b0;
         grid_width_q   = DIM_W'(GRID_SIDE);
         grid_height_q  = DIM_W'(GRID_SIDE);
         mismatch_count = 0;
         write_count    = 0;
         query_count    = 0;
         clear_count    = 0;
         visible_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_GRID_WIDTH)
               grid_width_q = csr_pwdata[DIM_W-1:0];
            else
               grid_height_q = csr_pwdata[DIM_W-1:0];
         end
         if (req_valid && !req_stall) begin
            if (req_operation == OP_WRITE) begin
               opacity_map[{req_cell_y, req_cell_x}] = req_opaque;
               write_count++;
            end else begin
               visible_due.push_back(sight_line_clear(int'(req_from_x), int'(req_from_y),
                                                      int'(req_to_x), int'(req_to_y)));
               query_count++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (visible_due.size() == 0) begin
               flag_mismatch("result beat with no query outstanding", 0, rsp_visible);
            end else begin
               if (visible_due[0])
                  clear_count++;
               if (rsp_visible !== visible_due[0])
                  flag_mismatch("visible", int'(visible_due[0]), rsp_visible);
               void'(visible_due.pop_front());
            end
         end
      end
      pending_count <= visible_due.size();
   end

endmodule

/* test/grid_line_of_sight_check_test.sv */
// Stimulus and verdict for the grid line-of-sight checker.
module grid_line_of_sight_check_test;
   import glos_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_operation;
   logic [CELL_W-1:0]  req_cell_x;
   logic [CELL_W-1:0]  req_cell_y;
   logic               req_opaque;
   logic [COORD_W-1:0] req_from_x;
   logic [COORD_W-1:0] req_from_y;
   logic [COORD_W-1:0] req_to_x;
   logic [COORD_W-1:0] req_to_y;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_visible;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [2:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   int mismatch_count;
   int pending_count;
   int write_count;
   int query_count;
   int clear_count;

   // Idle mix, pending long hold-off and the grid span in use
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_ask       = 0;
   int hold_left      = 0;
   int span_x         = GRID_SIDE;
   int span_y         = GRID_SIDE;

   grid_line_of_sight_check u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .req_opaque    (req_opaque),
      .req_from_x    (req_from_x),
      .req_from_y    (req_from_y),
      .req_to_x      (req_to_x),
      .req_to_y      (req_to_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_visible   (rsp_visible),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   sight_query_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_opaque     (req_opaque),
      .req_from_x     (req_from_x),
      .req_from_y     (req_from_y),
      .req_to_x       (req_to_x),
      .req_to_y       (req_to_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_visible    (rsp_visible),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .write_count    (write_count),
      .query_count    (query_count),
      .clear_count    (clear_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit, far beyond the slowest correct run
   initial begin
      #30_000_000;
      $display("FAIL grid_line_of_sight_check");
      $finish;
   end

   // Result side: random stalls, or a long hold-off counted here when asked
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_ask != 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // One beat on the item channel; valid stays up on return unless the caller drops it
   task automatic offer_beat(logic op, logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy,
                             logic opq, logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
                             logic [COORD_W-1:0] tx, logic [COORD_W-1:0] ty);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_cell_x    <= cx;
      req_cell_y    <= cy;
      req_opaque    <= opq;
      req_from_x    <= fx;
      req_from_y    <= fy;
      req_to_x      <= tx;
      req_to_y      <= ty;
      do @(posedge clock); while (req_stall);
   endtask

   // Cell write with noise on the query fields
   task automatic put_cell(int x, int y, logic opq);
      offer_beat(OP_WRITE, CELL_W'(x), CELL_W'(y), opq, COORD_W'($urandom()),
                 COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()));
   endtask

   // Sight query with noise on the write fields
   task automatic ask_sight(int fx, int fy, int tx, int ty);
      offer_beat(OP_QUERY, CELL_W'($urandom()), CELL_W'($urandom()),
                 1'($urandom_range(1)), COORD_W'(fx), COORD_W'(fy),
                 COORD_W'(tx), COORD_W'(ty));
   endtask

   // APB write: setup cycle, then access cycle until pready
   task automatic write_csr(logic sel, logic [DIM_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= {24'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(int w, int h);
      write_csr(REG_GRID_WIDTH, DIM_W'(w));
      write_csr(REG_GRID_HEIGHT, DIM_W'(h));
      span_x = (w > GRID_SIDE) ? GRID_SIDE : ((w < 1) ? 1 : w);
      span_y = (h > GRID_SIDE) ? GRID_SIDE : ((h < 1) ? 1 : h);
   endtask

   // Drop valid, let every result come back, then give the core time to go idle
   task automatic drain_to_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (400) @(posedge clock);
   endtask

   // Mostly in-grid writes and queries aimed at rows, columns, knight and short hops
   task automatic offer_random_item(int win);
      int wx, wy, pick, ox, oy;
      int fx, fy, tx, ty;
      wx = (win < span_x) ? win : span_x;
      wy = (win < span_y) ? win : span_y;
      if ($urandom_range(99) < 35) begin
         if ($urandom_range(9) < 7)
            put_cell($urandom_range(wx - 1), $urandom_range(wy - 1), $urandom_range(99) < 35);
         else
            put_cell($urandom_range(GRID_SIDE - 1), $urandom_range(GRID_SIDE - 1),
                     1'($urandom_range(1)));
         return;
      end
      fx   = $urandom_range(wx - 1);
      fy   = $urandom_range(wy - 1);
      pick = $urandom_range(99);
      if (pick < 45) begin
         tx = $urandom_range(wx - 1);
         ty = $urandom_range(wy - 1);
      end else if (pick < 60) begin
         tx = fx + int'($urandom_range(6)) - 3;
         ty = fy + int'($urandom_range(6)) - 3;
      end else if (pick < 72) begin
         if ($urandom_range(1)) begin
            tx = fx;
            ty = $urandom_range(wy - 1);
         end else begin
            tx = $urandom_range(wx - 1);
            ty = fy;
         end
      end else if (pick < 85) begin
         ox = $urandom_range(1) ? 1 : 2;
         oy = 3 - ox;
         if ($urandom_range(1))
            ox = -ox;
         if ($urandom_range(1))
            oy = -oy;
         tx = fx + ox;
         ty = fy + oy;
      end else begin
         fx = $urandom();
         fy = $urandom();
         tx = $urandom();
         ty = $urandom();
      end
      ask_sight(fx, fy, tx, ty);
   endtask

   initial begin
      int waited;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_WRITE;
      req_cell_x    <= '0;
      req_cell_y    <= '0;
      req_opaque    <= 1'b0;
      req_from_x    <= '0;
      req_from_y    <= '0;
      req_to_x      <= '0;
      req_to_y      <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: full grid, clear map; CSR writes land during the clearing sweep
      set_grid(GRID_SIDE, GRID_SIDE);
      put_cell(5, 5, 1'b1);
      ask_sight(3, 5, 7, 5);        // row through a wall
      ask_sight(5, 3, 5, 7);        // column through a wall
      ask_sight(5, 5, 5, 5);        // same cell
      ask_sight(4, 4, 5, 5);        // neighbors
      ask_sight(0, 5, 5, 5);        // opaque target itself is not in the way
      put_cell(10, 11, 1'b1);
      ask_sight(10, 10, 11, 12);    // knight with blocked near cell
      ask_sight(20, 20, 21, 22);    // knight, open
      ask_sight(20, 20, 22, 19);    // knight, flat orientation
      ask_sight(128, 0, 0, 0);      // viewer off the grid
      ask_sight(0, 0, 0, 255);      // target far off the grid
      ask_sight(0, 0, 127, 127);    // full diagonal
      put_cell(127, 0, 1'b1);
      put_cell(0, 127, 1'b1);
      ask_sight(0, 0, 127, 0);      // full row ending on an opaque cell
      ask_sight(127, 0, 0, 127);    // anti-diagonal between opaque corners
      put_cell(31, 30, 1'b1);
      ask_sight(30, 30, 34, 32);    // shallow walk
      ask_sight(30, 29, 33, 31);    // walk turning at a corner cell
      ask_sight(6, 8, 12, 17);      // steep walk
      put_cell(5, 5, 1'b0);
      ask_sight(3, 5, 7, 5);        // wall cleared again
      put_cell(127, 127, 1'b1);
      ask_sight(255, 255, 255, 255);
      drain_to_idle();

      // Small grid, slow sender, busy receiver
      send_idle_pct  = 14;
      recv_stall_pct = 83;
      set_grid(16, 12);
      repeat (230) offer_random_item(16);
      drain_to_idle();

      // Zero width: nothing is ever in sight
      set_grid(0, GRID_SIDE);
      repeat (15) offer_random_item(GRID_SIDE);
      drain_to_idle();

      // One row tall
      set_grid(GRID_SIDE, 1);
      repeat (15) offer_random_item(24);
      drain_to_idle();

      // Oversized width, idle mix swapped
      send_idle_pct  = 83;
      recv_stall_pct = 14;
      set_grid(255, 24);
      repeat (220) offer_random_item(24);
      drain_to_idle();

      // No idling; long hold-off on results while queries keep coming
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      set_grid(200, GRID_SIDE);
      hold_ask = 400;
      repeat (25) offer_random_item(32);
      repeat (200) offer_random_item(($urandom_range(99) < 20) ? GRID_SIDE : 40);

      // Wind down and give the verdict
      req_valid <= 1'b0;
      waited = 0;
      while (pending_count != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (400) @(posedge clock);
      if (pending_count != 0)
         $display("%0d queries never answered", pending_count);
      $display("Ran %0d cell writes and %0d queries (%0d in sight) over six grid sizes,",
               write_count, query_count, clear_count);
      $display("three idle mixes and one long result hold-off.");
      if (mismatch_count == 0 && pending_count == 0)
         $display("PASS grid_line_of_sight_check");
      else
         $display("FAIL grid_line_of_sight_check");
      $finish;
   end

endmodule
